### hw/rtl/incidence_matrix_graph_store_unit_defines.svh
// Assertion macros for the incidence matrix graph store.
// Used by the top level; expects clk and arst_n in scope.
`ifndef INCIDENCE_MATRIX_GRAPH_STORE_UNIT_DEFINES_SVH
`define INCIDENCE_MATRIX_GRAPH_STORE_UNIT_DEFINES_SVH

// Condition that must hold at every edge out of reset.
`define IMGS_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define IMGS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/imgs_pkg.sv
// Shared types and codes for the incidence matrix graph store.
// No dependencies.
`default_nettype none

package imgs_pkg;

	typedef enum logic [2:0] {
		ACT_INIT       = 3'd0,
		ACT_ADD        = 3'd1,
		ACT_SET_NEWEST = 3'd2,
		ACT_GET        = 3'd3,
		ACT_SET        = 3'd4,
		ACT_UNDIR      = 3'd5,
		ACT_DIR        = 3'd6
	} action_t;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_RANGE = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	localparam logic [6:0] VCOUNT_RESET = 7'd64;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_GET,
		ST_SWEEP,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [2:0]         action;
		logic [8:0]         edge_index;
		logic [5:0]         vertex_a;
		logic [5:0]         vertex_b;
		logic signed [15:0] entry_value;
	} req_t;

	typedef struct packed {
		logic signed [15:0] read_value;
		logic               connected;
		logic [1:0]         status;
		logic [8:0]         edges_in_use;
	} res_t;

	// Column valid bit commands
	typedef struct packed {
		logic clear_all;
		logic clear_one;
		logic set_one;
	} cv_cmd_t;

endpackage

`default_nettype wire

### hw/rtl/imgs_ram.sv
// Generic synchronous RAM: one write port, two registered read ports.
// No dependencies.
`default_nettype none

module imgs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16384
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic      [WIDTH-1:0]         rdata_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

`default_nettype wire

### hw/rtl/imgs_col_valid.sv
// Per-column valid bits; a column not valid reads as all zero.
// Depends on imgs_pkg.
`default_nettype none

module imgs_col_valid #(
	parameter int N  = 256,
	parameter int IW = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire imgs_pkg::cv_cmd_t cmd,
	input  wire logic [IW-1:0]     widx,
	input  wire logic [IW-1:0]     ridx,
	output logic                   rvalid
);
	import imgs_pkg::*;

	logic [N-1:0] valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.clear_all) begin
			valid_q <= '0;
		end else if (cmd.clear_one) begin
			valid_q[widx] <= 1'b0;
		end else if (cmd.set_one) begin
			valid_q[widx] <= 1'b1;
		end
	end

	assign rvalid = valid_q[ridx];

endmodule

`default_nettype wire

### hw/rtl/imgs_seq.sv
// Operation sequencer: decodes one transaction, drives the matrix RAM and
// column valid bits, scans columns for the connectivity tests. Uses imgs_pkg.
`default_nettype none

module imgs_seq #(
	parameter int MAX_EDGES    = 256,
	parameter int MAX_VERTICES = 64,
	parameter int ENTRY_BITS   = 16,
	parameter int EW           = 8,
	parameter int VW           = 6,
	parameter int CW           = 9
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire imgs_pkg::req_t       req,
	input  wire logic [6:0]           vertex_count,
	input  wire logic                 out_free,
	output logic                      idle,
	output logic                      done,
	output imgs_pkg::res_t            res,
	// matrix RAM
	output logic                      mem_we,
	output logic [EW+VW-1:0]          mem_waddr,
	output logic [ENTRY_BITS-1:0]     mem_wdata,
	output logic [EW+VW-1:0]          mem_raddr_a,
	output logic [EW+VW-1:0]          mem_raddr_b,
	input  wire logic [ENTRY_BITS-1:0] mem_rdata_a,
	input  wire logic [ENTRY_BITS-1:0] mem_rdata_b,
	// column valid bits
	output imgs_pkg::cv_cmd_t         cv_cmd,
	output logic [EW-1:0]             cv_widx,
	output logic [EW-1:0]             cv_ridx,
	input  wire logic                 cv_rvalid
);
	import imgs_pkg::*;

	localparam int CMPW = (CW > 9) ? CW : 9;

	state_t state_q, state_d;
	req_t   req_q;

	logic [CW-1:0] edge_count_q;
	logic [CW-1:0] count_m1;
	logic [EW-1:0] col_q;
	logic [VW-1:0] row_q;
	logic [CW-1:0] scan_q;
	logic          rd_s1;
	logic          colok_s1;
	logic          col_ok_q;
	logic [15:0]   rd_q;
	logic          conn_q;
	logic [1:0]    status_q;

	logic          va_ok, vb_ok, eidx_in, init_ok, full, entry_ok;
	logic [EW-1:0] tcol, scan_col;
	logic [VW-1:0] row_a, row_b;
	logic          issue, hit, sweep_last;
	logic signed [31:0]   val32, rd32;
	logic [ENTRY_BITS-1:0] wval;

	// decode of the held request
	assign va_ok    = (7'(req_q.vertex_a) < vertex_count) && (32'(req_q.vertex_a) < MAX_VERTICES);
	assign vb_ok    = (7'(req_q.vertex_b) < vertex_count) && (32'(req_q.vertex_b) < MAX_VERTICES);
	assign eidx_in  = CMPW'(req_q.edge_index) < CMPW'(edge_count_q);
	assign init_ok  = 32'(req_q.edge_index) <= MAX_EDGES;
	assign full     = edge_count_q == CW'(MAX_EDGES);
	assign count_m1 = edge_count_q - 1'b1;
	assign row_a    = VW'(req_q.vertex_a);
	assign row_b    = VW'(req_q.vertex_b);
	assign scan_col = scan_q[EW-1:0];
	assign val32    = 32'(req_q.entry_value);
	assign wval     = val32[ENTRY_BITS-1:0];
	assign rd32     = 32'(signed'(mem_rdata_a));

	always_comb begin
		if (req_q.action == ACT_SET_NEWEST) begin
			tcol     = count_m1[EW-1:0];
			entry_ok = (edge_count_q != '0) && va_ok;
		end else begin
			tcol     = EW'(req_q.edge_index);
			entry_ok = eidx_in && va_ok;
		end
	end

	assign issue      = (state_q == ST_SCAN) && (scan_q < edge_count_q);
	assign sweep_last = row_q == VW'(MAX_VERTICES - 1);

	always_comb begin
		if (req_q.action == ACT_DIR) begin
			hit = rd_s1 && colok_s1 && (mem_rdata_a == ENTRY_BITS'(1)) && (mem_rdata_b == '1);
		end else begin
			hit = rd_s1 && colok_s1 && (mem_rdata_a != '0) && (mem_rdata_b != '0);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				unique case (req_q.action) inside
					ACT_SET_NEWEST, ACT_SET: begin
						state_d = (entry_ok && !cv_rvalid) ? ST_SWEEP : ST_DONE;
					end
					ACT_GET: state_d = entry_ok ? ST_GET : ST_DONE;
					ACT_UNDIR, ACT_DIR: state_d = (va_ok && vb_ok) ? ST_SCAN : ST_DONE;
					default: state_d = ST_DONE;
				endcase
			end
			ST_GET: state_d = ST_DONE;
			ST_SWEEP: begin
				if (sweep_last) state_d = ST_DONE;
			end
			ST_SCAN: begin
				if (hit || (!issue && !rd_s1)) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory and valid bit controls
	always_comb begin
		mem_we      = 1'b0;
		mem_waddr   = {tcol, row_a};
		mem_wdata   = wval;
		mem_raddr_a = {tcol, row_a};
		mem_raddr_b = {tcol, row_b};
		cv_cmd      = '0;
		cv_widx     = edge_count_q[EW-1:0];
		cv_ridx     = tcol;
		unique case (state_q)
			ST_EXEC: begin
				unique case (req_q.action) inside
					ACT_INIT: cv_cmd.clear_all = init_ok;
					ACT_ADD: cv_cmd.clear_one = !full;
					ACT_SET_NEWEST, ACT_SET: mem_we = entry_ok && cv_rvalid;
					default: ;
				endcase
			end
			ST_SWEEP: begin
				mem_we         = 1'b1;
				mem_waddr      = {col_q, row_q};
				mem_wdata      = (row_q == row_a) ? wval : '0;
				cv_cmd.set_one = sweep_last;
				cv_widx        = col_q;
			end
			ST_SCAN: begin
				mem_raddr_a = {scan_col, row_a};
				mem_raddr_b = {scan_col, row_b};
				cv_ridx     = scan_col;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			edge_count_q <= '0;
			rd_s1        <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_s1   <= issue;
			if (state_q == ST_EXEC) begin
				if (req_q.action == ACT_INIT && init_ok) begin
					edge_count_q <= CW'(req_q.edge_index);
				end else if (req_q.action == ACT_ADD && !full) begin
					edge_count_q <= edge_count_q + 1'b1;
				end
			end
		end
	end

	// payload and result registers
	always_ff @(posedge clk) begin
		colok_s1 <= cv_rvalid;
		if (start && state_q == ST_IDLE) begin
			req_q <= req;
		end
		case (state_q)
			ST_EXEC: begin
				status_q <= STAT_OK;
				conn_q   <= 1'b0;
				rd_q     <= '0;
				col_q    <= tcol;
				row_q    <= '0;
				scan_q   <= '0;
				col_ok_q <= cv_rvalid;
				case (req_q.action) inside
					ACT_INIT: if (!init_ok) status_q <= STAT_RANGE;
					ACT_ADD: if (full) status_q <= STAT_FULL;
					ACT_SET_NEWEST, ACT_SET, ACT_GET: if (!entry_ok) status_q <= STAT_RANGE;
					ACT_UNDIR, ACT_DIR: if (!(va_ok && vb_ok)) status_q <= STAT_RANGE;
					default: ;
				endcase
			end
			ST_GET: rd_q <= col_ok_q ? rd32[15:0] : '0;
			ST_SWEEP: row_q <= row_q + 1'b1;
			ST_SCAN: begin
				if (issue) scan_q <= scan_q + 1'b1;
				if (hit) conn_q <= 1'b1;
			end
			default: ;
		endcase
	end

	assign idle             = state_q == ST_IDLE;
	assign done             = (state_q == ST_DONE) && out_free;
	assign res.read_value   = rd_q;
	assign res.connected    = conn_q;
	assign res.status       = status_q;
	assign res.edges_in_use = 9'(edge_count_q);

endmodule

`default_nettype wire

### hw/rtl/incidence_matrix_graph_store_unit.sv
// Top level of the incidence matrix graph store: channel registers,
// vertex_count register, sequencer, column valid bits and matrix RAM.
// Depends on imgs_pkg, imgs_ram, imgs_col_valid, imgs_seq and the defines header.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+--------------------------------------
//  s_      | in  | s_tvalid/s_tready | tuser action, tdata edge/vertex/value
//  m_      | out | m_tvalid/m_tready | tuser status, tdata read/conn/count
//  cfg_    | in  | cfg_valid/ready   | cfg_data vertex_count
//
// One transaction at a time. Init, add edge and a set into a valid column go
// from EXEC straight to DONE; get passes through GET for the RAM read. A set
// into a column not yet written sweeps every row of the column in the RAM write
// port. Connectivity tests read two entries per edge through both RAM read
// ports, one edge a cycle, and stop early on a hit.
// Reset needs no clearing pass: per-column valid bits mask stale RAM contents.
// A result waiting on m_tready holds the next transaction in its final cycle.
`default_nettype none

`include "incidence_matrix_graph_store_unit_defines.svh"

module incidence_matrix_graph_store_unit #(
	parameter int MAX_EDGES    = 256,
	parameter int MAX_VERTICES = 64,
	parameter int ENTRY_BITS   = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // edge_index[8:0], vertex_a, vertex_b, entry_value, pad
	input  wire logic [2:0]  s_tuser,  // action
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // read_value[15:0], connected, edges_in_use, pad
	output logic [1:0]       m_tuser,  // status
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [6:0]  cfg_data  // vertex_count
);
	import imgs_pkg::*;

	localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CW = $clog2(MAX_EDGES + 1);
	localparam int AW = EW + VW;

	logic [6:0] vertex_count_q;
	req_t       req;
	res_t       res;
	logic       idle, done, out_free;
	logic       m_tvalid_q;
	logic [31:0] m_tdata_q;
	logic [1:0]  m_tuser_q;

	logic                  mem_we;
	logic [AW-1:0]         mem_waddr, mem_raddr_a, mem_raddr_b;
	logic [ENTRY_BITS-1:0] mem_wdata, mem_rdata_a, mem_rdata_b;
	cv_cmd_t               cv_cmd;
	logic [EW-1:0]         cv_widx, cv_ridx;
	logic                  cv_rvalid;

	// configuration: always ready; the user must write it only while idle (not enforced)
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VCOUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			vertex_count_q <= cfg_data;
		end
	end

	// input unpack
	assign req.action      = s_tuser;
	assign req.edge_index  = s_tdata[8:0];
	assign req.vertex_a    = s_tdata[14:9];
	assign req.vertex_b    = s_tdata[20:15];
	assign req.entry_value = s_tdata[36:21];

	assign s_tready = idle;

	// output register: frees the sequencer once the result is parked
	assign out_free = !m_tvalid_q || m_tready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (done) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			m_tdata_q <= {6'd0, res.edges_in_use, res.connected, res.read_value};
			m_tuser_q <= res.status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	imgs_seq #(
		.MAX_EDGES    (MAX_EDGES),
		.MAX_VERTICES (MAX_VERTICES),
		.ENTRY_BITS   (ENTRY_BITS),
		.EW           (EW),
		.VW           (VW),
		.CW           (CW)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (s_tvalid && s_tready),
		.req          (req),
		.vertex_count (vertex_count_q),
		.out_free     (out_free),
		.idle         (idle),
		.done         (done),
		.res          (res),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_raddr_a  (mem_raddr_a),
		.mem_raddr_b  (mem_raddr_b),
		.mem_rdata_a  (mem_rdata_a),
		.mem_rdata_b  (mem_rdata_b),
		.cv_cmd       (cv_cmd),
		.cv_widx      (cv_widx),
		.cv_ridx      (cv_ridx),
		.cv_rvalid    (cv_rvalid)
	);

	imgs_col_valid #(
		.N  (MAX_EDGES),
		.IW (EW)
	) u_col_valid (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cv_cmd),
		.widx   (cv_widx),
		.ridx   (cv_ridx),
		.rvalid (cv_rvalid)
	);

	// matrix: address is {edge column, vertex row}
	imgs_ram #(
		.WIDTH (ENTRY_BITS),
		.DEPTH (1 << AW)
	) u_matrix (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.raddr_a (mem_raddr_a),
		.rdata_a (mem_rdata_a),
		.raddr_b (mem_raddr_b),
		.rdata_b (mem_rdata_b)
	);

	// one transaction in flight: the sequencer is busy straight after accepting
	`IMGS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted while busy")
	// a result is never parked over one still waiting
	`IMGS_ASSERT(a_no_overwrite, !done || !m_tvalid_q || m_tready, "result overwritten")
	// store full only reported with the count at its limit
	`IMGS_ASSERT(a_full_count, !(m_tvalid && m_tuser == STAT_FULL) || m_tdata[25:17] == 9'(MAX_EDGES), "full with spare columns")

endmodule

`default_nettype wire

### dv/incidence_matrix_graph_store_unit_test.sv
// Self-checking bench for the incidence matrix graph store: directed cases, then random
// edge building and connectivity queries, checked against an in-bench graph predictor.
// Depends on imgs_pkg and incidence_matrix_graph_store_unit.
`timescale 1ns / 100ps

module incidence_matrix_graph_store_unit_test;
	import imgs_pkg::*;

	localparam int EDGE_CAP    = 256;
	localparam int ROW_CAP     = 64;
	localparam int CYCLE_LIMIT = 2_000_000;
	// end-of-run settle: longest column sweep or edge scan, with margin
	localparam int DRAIN_CYCLES = 300;

	// code left out of action_t; the block must ignore it
	localparam logic [2:0] ACT_UNUSED = 3'd7;

	localparam logic signed [15:0] TAIL_MARK = 16'sd1;
	localparam logic signed [15:0] HEAD_MARK = -16'sd1;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;  // edge_index, vertex_a, vertex_b, entry_value, pad
	logic [2:0]  s_tuser;  // action
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;  // read_value, connected, edges_in_use, pad
	logic [1:0]  m_tuser;  // status
	logic        cfg_valid;
	logic        cfg_ready;
	logic [6:0]  cfg_data;

	incidence_matrix_graph_store_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// Predictor state: matrix, edge columns in use, vertex_count register
	logic signed [15:0] graph_cells [EDGE_CAP][ROW_CAP];
	int                 edges_held;
	logic [6:0]         vertex_count_reg;

	res_t awaited_results [$];
	int   mismatch_count;
	int   items_sent;
	int   cycle_count;
	bit   stall_source;
	bit   stall_sink;

	// vertex pairs of recently built edges, so queries actually hit
	int recent_tails [$];
	int recent_heads [$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop should the block hang
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int vertex_limit();
		return (vertex_count_reg < ROW_CAP) ? int'(vertex_count_reg) : ROW_CAP;
	endfunction

	// Applies one operation to the graph copy and returns the result it should give
	function automatic res_t apply_graph_op(logic [2:0] act, logic [8:0] eidx,
			logic [5:0] va, logic [5:0] vb, logic signed [15:0] val);
		res_t r;
		int   lim;
		int   e;
		r = '0;
		lim = vertex_limit();
		case (act)
			ACT_INIT: begin
				if (eidx > EDGE_CAP) begin
					r.status = STAT_RANGE;
				end else begin
					foreach (graph_cells[i, j]) graph_cells[i][j] = '0;
					edges_held = eidx;
				end
			end
			ACT_ADD: begin
				if (edges_held >= EDGE_CAP) begin
					r.status = STAT_FULL;
				end else begin
					for (e = 0; e < ROW_CAP; e++) graph_cells[edges_held][e] = '0;
					edges_held++;
				end
			end
			ACT_SET_NEWEST: begin
				if (edges_held == 0 || va >= lim) r.status = STAT_RANGE;
				else graph_cells[edges_held - 1][va] = val;
			end
			ACT_GET: begin
				if (eidx >= edges_held || va >= lim) r.status = STAT_RANGE;
				else r.read_value = graph_cells[eidx][va];
			end
			ACT_SET: begin
				if (eidx >= edges_held || va >= lim) r.status = STAT_RANGE;
				else graph_cells[eidx][va] = val;
			end
			ACT_UNDIR, ACT_DIR: begin
				if (va >= lim || vb >= lim) begin
					r.status = STAT_RANGE;
				end else begin
					// first matching column ends the scan
					for (e = 0; e < edges_held && !r.connected; e++) begin
						if (act == ACT_UNDIR)
							r.connected = (graph_cells[e][va] != 0) && (graph_cells[e][vb] != 0);
						else
							r.connected = (graph_cells[e][va] == TAIL_MARK) &&
								(graph_cells[e][vb] == HEAD_MARK);
					end
				end
			end
			default: ;
		endcase
		r.edges_in_use = edges_held[8:0];
		return r;
	endfunction

	// One request transaction; the expectation is queued at the accepting edge
	task automatic send_item(input logic [2:0] act, input logic [8:0] eidx,
			input logic [5:0] va, input logic [5:0] vb, input logic signed [15:0] val);
		int gap;
		if (stall_source && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 19);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {3'b000, val, vb, va, eidx};
		do @(posedge clk); while (!s_tready);
		awaited_results.push_back(apply_graph_op(act, eidx, va, vb, val));
		items_sent++;
		if (act == ACT_INIT) begin
			recent_tails.delete();
			recent_heads.delete();
		end
	endtask

	// Drops valid, waits out every outstanding result, then lets the block settle
	task automatic wait_idle(input int settle);
		s_tvalid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_vertex_count(input logic [6:0] count);
		wait_idle(4);
		cfg_valid <= 1'b1;
		cfg_data  <= count;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		vertex_count_reg = count;
	endtask

	// Mostly rows in use, now and then any row
	function automatic logic [5:0] pick_vertex();
		int lim;
		lim = vertex_limit();
		if (lim == 0 || $urandom_range(0, 9) == 0) return 6'($urandom_range(0, 63));
		return 6'($urandom_range(0, lim - 1));
	endfunction

	// Result checker: each result against the oldest expectation
	always @(posedge clk) begin : check_results
		res_t got;
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.read_value   = m_tdata[15:0];
			got.connected    = m_tdata[16];
			got.edges_in_use = m_tdata[25:17];
			got.status       = m_tuser;
			if (awaited_results.size() == 0) begin
				$display("%0t: result with none expected: read %0d conn %0d status %0d edges %0d",
					$time, got.read_value, got.connected, got.status, got.edges_in_use);
				mismatch_count++;
			end else begin
				want = awaited_results.pop_front();
				if (got.read_value !== want.read_value) begin
					$display("%0t: read_value expected %0d actual %0d",
						$time, want.read_value, got.read_value);
					mismatch_count++;
				end
				if (got.connected !== want.connected) begin
					$display("%0t: connected expected %0d actual %0d",
						$time, want.connected, got.connected);
					mismatch_count++;
				end
				if (got.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, got.status);
					mismatch_count++;
				end
				if (got.edges_in_use !== want.edges_in_use) begin
					$display("%0t: edges_in_use expected %0d actual %0d",
						$time, want.edges_in_use, got.edges_in_use);
					mismatch_count++;
				end
			end
		end
	end

	// Result sink: back-pressure in random bursts while stall_sink is set
	initial begin
		m_tready <= 1'b1;
		forever begin
			@(posedge clk);
			if (stall_sink && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	// Empty store straight out of reset
	task automatic test_reset_state();
		send_item(ACT_GET, 9'd0, 6'd0, 6'd0, 16'sd0);
		send_item(ACT_SET_NEWEST, 9'd0, 6'd0, 6'd0, TAIL_MARK);
		send_item(ACT_DIR, 9'd0, 6'd0, 6'd63, 16'sd0);
		send_item(ACT_UNUSED, 9'h1FF, 6'h3F, 6'h3F, 16'shFFFF);
	endtask

	// Extreme rows, extreme values, both directions of one edge
	task automatic test_edge_extremes();
		send_item(ACT_INIT, 9'd0, 6'd0, 6'd0, 16'sd0);
		send_item(ACT_ADD, 9'd0, 6'd0, 6'd0, 16'sd0);
		send_item(ACT_SET_NEWEST, 9'd0, 6'd0, 6'd0, TAIL_MARK);
		send_item(ACT_SET_NEWEST, 9'd0, 6'd63, 6'd0, HEAD_MARK);
		send_item(ACT_DIR, 9'd0, 6'd0, 6'd63, 16'sd0);
		send_item(ACT_DIR, 9'd0, 6'd63, 6'd0, 16'sd0);
		send_item(ACT_UNDIR, 9'd0, 6'd63, 6'd0, 16'sd0);
		send_item(ACT_UNDIR, 9'd0, 6'd5, 6'd5, 16'sd0);
		send_item(ACT_GET, 9'd0, 6'd63, 6'd0, 16'sd0);
		send_item(ACT_SET, 9'd0, 6'd5, 6'd0, 16'sh7FFF);
		send_item(ACT_GET, 9'd0, 6'd5, 6'd0, 16'sd0);
		send_item(ACT_SET, 9'd0, 6'd5, 6'd0, -16'sh8000);
		send_item(ACT_GET, 9'd0, 6'd5, 6'd0, 16'sd0);
		send_item(ACT_GET, 9'd1, 6'd5, 6'd0, 16'sd0);
	endtask

	// Full store rejects an add, init counts past the end, last column set and read back
	task automatic test_store_capacity();
		send_item(ACT_INIT, 9'd256, 6'd0, 6'd0, 16'sd0);
		send_item(ACT_ADD, 9'd0, 6'd0, 6'd0, 16'sd0);
		send_item(ACT_SET, 9'd255, 6'd63, 6'd0, -16'sd2);
		send_item(ACT_INIT, 9'd257, 6'd0, 6'd0, 16'sd0);
		send_item(ACT_INIT, 9'h1FF, 6'd0, 6'd0, 16'sd0);
		send_item(ACT_GET, 9'd255, 6'd63, 6'd0, 16'sd0);
	endtask

	// Vertex register: zero rejects all rows, narrowing hides rows without clearing them
	task automatic test_vertex_limit();
		write_vertex_count(7'd0);
		send_item(ACT_GET, 9'd0, 6'd0, 6'd0, 16'sd0);
		send_item(ACT_UNDIR, 9'd0, 6'd0, 6'd0, 16'sd0);
		write_vertex_count(7'd1);
		send_item(ACT_SET, 9'd0, 6'd0, 6'd0, 16'sd5);
		send_item(ACT_GET, 9'd255, 6'd63, 6'd0, 16'sd0);
		write_vertex_count(7'd127);
		send_item(ACT_GET, 9'd255, 6'd63, 6'd0, 16'sd0);
		write_vertex_count(VCOUNT_RESET);
	endtask

	// Random traffic: mostly edge building and queries on edges just built
	task automatic run_graph_traffic(input int count, input bit with_idle);
		int goal;
		int pick;
		int k;
		logic [5:0] ta;
		logic [5:0] hb;
		stall_source = with_idle;
		stall_sink   = with_idle;
		goal = items_sent + count;
		while (items_sent < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				send_item(ACT_ADD, 9'($urandom), 6'($urandom), 6'($urandom), 16'($urandom));
				ta = pick_vertex();
				hb = pick_vertex();
				k = $urandom_range(0, 9);
				if (k < 7) begin
					send_item(ACT_SET_NEWEST, 9'($urandom), ta, 6'($urandom), TAIL_MARK);
					send_item(ACT_SET_NEWEST, 9'($urandom), hb, 6'($urandom), HEAD_MARK);
				end else if (k < 9) begin
					send_item(ACT_SET_NEWEST, 9'($urandom), ta, 6'($urandom), TAIL_MARK);
					send_item(ACT_SET_NEWEST, 9'($urandom), hb, 6'($urandom), TAIL_MARK);
				end else begin
					send_item(ACT_SET_NEWEST, 9'($urandom), ta, 6'($urandom), 16'($urandom));
				end
				recent_tails.push_back(ta);
				recent_heads.push_back(hb);
				if (recent_tails.size() > 8) begin
					void'(recent_tails.pop_front());
					void'(recent_heads.pop_front());
				end
			end else if (pick < 65) begin
				if (recent_tails.size() != 0 && $urandom_range(0, 4) != 0) begin
					k = $urandom_range(0, recent_tails.size() - 1);
					ta = recent_tails[k];
					hb = recent_heads[k];
					if ($urandom_range(0, 3) == 0) {ta, hb} = {hb, ta};
				end else begin
					ta = pick_vertex();
					hb = pick_vertex();
				end
				send_item($urandom_range(0, 1) ? ACT_DIR : ACT_UNDIR, 9'($urandom),
					ta, hb, 16'($urandom));
			end else if (pick < 80) begin
				send_item(ACT_GET, ($urandom_range(0, 9) < 7) ?
					9'($urandom_range(0, edges_held)) : 9'($urandom),
					pick_vertex(), 6'($urandom), 16'($urandom));
			end else if (pick < 90) begin
				send_item(ACT_SET, ($urandom_range(0, 9) < 7) ?
					9'($urandom_range(0, edges_held)) : 9'($urandom),
					pick_vertex(), 6'($urandom), 16'($urandom));
			end else if (pick < 94) begin
				send_item(ACT_INIT, ($urandom_range(0, 6) != 0) ?
					9'($urandom_range(0, 6)) : 9'($urandom),
					6'($urandom), 6'($urandom), 16'($urandom));
			end else begin
				// noise: ignored code or stray newest-edge write
				send_item($urandom_range(0, 1) ? ACT_UNUSED : ACT_SET_NEWEST,
					9'($urandom), 6'($urandom), 6'($urandom), 16'($urandom));
			end
		end
	endtask

	// Random phases under several vertex limits; the last runs without idling
	task automatic test_random_mix();
		run_graph_traffic(220, 1'b1);
		write_vertex_count(7'd16);
		run_graph_traffic(220, 1'b0);
		write_vertex_count(7'd127);
		run_graph_traffic(200, 1'b1);
		write_vertex_count(7'd5);
		run_graph_traffic(200, 1'b1);
		write_vertex_count(7'd0);
		run_graph_traffic(60, 1'b1);
		write_vertex_count(7'($urandom_range(1, 127)));
		run_graph_traffic(200, 1'b1);
		write_vertex_count(7'd64);
		run_graph_traffic(200, 1'b0);
	endtask

	initial begin
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		mismatch_count = 0;
		items_sent     = 0;
		stall_source   = 1'b0;
		stall_sink     = 1'b0;
		edges_held     = 0;
		vertex_count_reg = VCOUNT_RESET;
		foreach (graph_cells[i, j]) graph_cells[i][j] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_edge_extremes();
		test_store_capacity();
		test_vertex_limit();
		test_random_mix();

		wait_idle(DRAIN_CYCLES);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
